// ----- src/skt_pkg.sv -----
// skt_pkg: shared types and codes for the sorted key table
// no dependencies
package skt_pkg;

  localparam int unsigned FieldKeyW  = 16;
  localparam int unsigned FieldSizeW = 8;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the accepted item
    logic apply;  // update the cells and the result register
  } cmd_t;

endpackage

// ----- src/skt_if.sv -----
// skt_in_if / skt_out_if: valid-ready channels of the sorted key table
// depends on skt_pkg for field widths
interface skt_in_if
  import skt_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [FieldKeyW-1:0]  item_key;
  logic [FieldSizeW-1:0] item_size;

  modport source (output valid, operation, item_key, item_size, input ready);
  modport sink   (input valid, operation, item_key, item_size, output ready);
endinterface

interface skt_out_if
  import skt_pkg::*;
#(
  parameter int unsigned CNT_W = 5
) ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [FieldKeyW-1:0]  found_key;
  logic [FieldSizeW-1:0] found_size;
  logic [CNT_W-1:0]      entry_count;

  modport source (output valid, status, found_key, found_size, entry_count, input ready);
  modport sink   (input valid, status, found_key, found_size, entry_count, output ready);
endinterface

// ----- src/skt_ctrl.sv -----
// skt_ctrl: two-state controller that sequences one item at a time
// depends on skt_pkg
module skt_ctrl
  import skt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_ready_i,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_BUSY;
        end
      end
      S_BUSY: begin
        if (slot_free) begin
          cmd_o.apply = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- src/skt_dp.sv -----
// skt_dp: row of compare-and-shift cells, fill count and result register
// depends on skt_pkg
module skt_dp
  import skt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned KEY_BITS = 16,
  parameter int unsigned CNT_W    = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  logic                  operation_i,
  input  logic [FieldKeyW-1:0]  item_key_i,
  input  logic [FieldSizeW-1:0] item_size_i,
  output logic [1:0]            status_o,
  output logic [FieldKeyW-1:0]  found_key_o,
  output logic [FieldSizeW-1:0] found_size_o,
  output logic [CNT_W-1:0]      entry_count_o
);

  // captured item
  logic                  op_q;
  logic [KEY_BITS-1:0]   key_in_q;
  logic [FieldSizeW-1:0] size_in_q;

  // cells
  logic [KEY_BITS-1:0]   key_q  [CAPACITY];
  logic [FieldSizeW-1:0] size_q [CAPACITY];
  logic [CNT_W-1:0]      count_q;

  logic [CAPACITY-1:0] lt, eq, prev_lt, hit;
  logic                found, full, do_ins, do_rem;
  logic [FieldSizeW-1:0] hit_size;

  // result register
  status_e               status_q;
  logic [FieldKeyW-1:0]  fkey_q;
  logic [FieldSizeW-1:0] fsize_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= operation_i;
      key_in_q  <= KEY_BITS'(item_key_i);
      size_in_q <= item_size_i;
    end
  end

  assign full   = (count_q == CNT_W'(CAPACITY));
  assign found  = |hit;
  assign do_ins = cmd_i.apply && (op_q == OP_INSERT) && !full;
  assign do_rem = cmd_i.apply && (op_q == OP_REMOVE) && found;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  held;
    logic [KEY_BITS-1:0]   up_key, dn_key;
    logic [FieldSizeW-1:0] up_size, dn_size;

    assign held  = (CNT_W'(i) < count_q);
    assign lt[i] = held && (key_q[i] < key_in_q);
    assign eq[i] = held && (key_q[i] == key_in_q);

    if (i == 0) begin : g_first
      assign prev_lt[i] = 1'b1;
      assign up_key     = key_in_q;
      assign up_size    = size_in_q;
    end else begin : g_rest
      assign prev_lt[i] = lt[i-1];
      assign up_key     = key_q[i-1];
      assign up_size    = size_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign dn_key  = key_q[i];
      assign dn_size = size_q[i];
    end else begin : g_mid
      assign dn_key  = key_q[i+1];
      assign dn_size = size_q[i+1];
    end

    // first held entry at or above the key, and equal to it
    assign hit[i] = eq[i] && prev_lt[i];

    always_ff @(posedge clk_i) begin
      if (do_ins && !lt[i]) begin
        if (prev_lt[i]) begin
          key_q[i]  <= key_in_q;
          size_q[i] <= size_in_q;
        end else begin
          key_q[i]  <= up_key;
          size_q[i] <= up_size;
        end
      end else if (do_rem && !lt[i]) begin
        key_q[i]  <= dn_key;
        size_q[i] <= dn_size;
      end
    end
  end

  always_comb begin
    hit_size = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      hit_size = hit_size | (size_q[i] & {FieldSizeW{hit[i]}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (do_ins) begin
      count_q <= count_q + CNT_W'(1);
    end else if (do_rem) begin
      count_q <= count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      fkey_q  <= '0;
      fsize_q <= '0;
      if (op_q == OP_INSERT) begin
        status_q <= full ? ST_FULL : ST_DONE;
      end else if (found) begin
        status_q <= ST_DONE;
        fkey_q   <= FieldKeyW'(key_in_q);
        fsize_q  <= hit_size;
      end else begin
        status_q <= ST_NOT_FOUND;
      end
    end
  end

  assign status_o      = status_q;
  assign found_key_o   = fkey_q;
  assign found_size_o  = fsize_q;
  assign entry_count_o = count_q;

endmodule

// ----- src/sorted_key_table.sv -----
// sorted_key_table: top level of the sorted key table
// depends on skt_pkg, skt_if, skt_ctrl and skt_dp
//
// usage
//   in_if carries one item: operation (insert or remove by key), item_key
//   and item_size. out_if returns exactly one result item for each:
//   status, found_key, found_size and the entry count after the item.
//   entries are held in ascending key order; a new entry goes ahead of
//   equal keys, and a remove takes the first matching entry
// sequencing
//   an item is captured on acceptance and settled in the busy state once the
//   output register is free, when the cell row compares every held key against
//   it and shifts in one step; the result is written to the output register
//   as the cells update. a new item is accepted only after the previous one
//   has been applied to the compare-and-shift cell row, used once per item
// reset
//   rst_ni clears the fill count and the handshake state; key and size
//   cells hold no reset value and are only read once written
// stalls
//   a result waits in the output register while out_if.ready is low; the
//   next item is still accepted, then held until the register frees up
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned KEY_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  skt_in_if.sink     in_if,
  skt_out_if.source  out_if
);

  // width of the entry count, 0 up to CAPACITY
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // command bundle from controller to cells
  cmd_t cmd;

  // sequencing and output valid
  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .cmd_o       (cmd)
  );

  // cell row, fill count and result payload
  skt_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .CNT_W    (CntW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .operation_i   (in_if.operation),
    .item_key_i    (in_if.item_key),
    .item_size_i   (in_if.item_size),
    .status_o      (out_if.status),
    .found_key_o   (out_if.found_key),
    .found_size_o  (out_if.found_size),
    .entry_count_o (out_if.entry_count)
  );

endmodule
